// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

   localparam int ENTRY_W = 16;
   localparam int N_ENTRY = 9;
   localparam int PROD_W  = 32;
   localparam int ADJ_W   = 33;
   localparam int DET_W   = 49;
   localparam int DM_W    = 48;
   localparam int CM_W    = 32;
   localparam int Q_W     = 34;
   localparam int OUT_W   = 32;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic signed [ADJ_W-1:0]   adj_type;
   typedef logic signed [DET_W-1:0]   det_type;

   // each adjugate entry is pa*pb - pc*pd over the flattened matrix
   localparam int PA [N_ENTRY] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int PB [N_ENTRY] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int PC [N_ENTRY] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int PD [N_ENTRY] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   typedef struct packed {
      adj_type [N_ENTRY-1:0] adj;
      det_type               det;
      logic                  singular;
   } front_item_type;

endpackage

// ===== rtl/mi3_front.sv =====
module mi3_front
   import mi3_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [N_ENTRY*ENTRY_W-1:0]     in_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output front_item_type                 out_item
);

   entry_type m [N_ENTRY];
   logic en;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [PROD_W-1:0] pl_ff [N_ENTRY];
   logic signed [PROD_W-1:0] pr_ff [N_ENTRY];
   entry_type top1_ff [3];
   entry_type top2_ff [3];
   adj_type adj2_ff [N_ENTRY];
   adj_type adj3_ff [N_ENTRY];
   logic signed [DET_W-1:0] t_ff [3];
   front_item_type item4_ff;
   logic signed [DET_W-1:0] det_sum;

   always_comb begin
      for (int i = 0; i < N_ENTRY; i++) begin
         m[i] = in_data[i*ENTRY_W +: ENTRY_W];
      end
   end

   assign en       = !v4_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // three terms of at most 2^46 each, so the sum stays inside DET_W bits
   assign det_sum = t_ff[0] + t_ff[1] + t_ff[2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N_ENTRY; i++) begin
            pl_ff[i]   <= m[PA[i]] * m[PB[i]];
            pr_ff[i]   <= m[PC[i]] * m[PD[i]];
            adj2_ff[i] <= ADJ_W'(pl_ff[i]) - ADJ_W'(pr_ff[i]);
            adj3_ff[i] <= adj2_ff[i];
            item4_ff.adj[i] <= adj3_ff[i];
         end
         for (int j = 0; j < 3; j++) begin
            top1_ff[j] <= m[j];
            top2_ff[j] <= top1_ff[j];
         end
         // expansion along the first row
         t_ff[0] <= DET_W'(top2_ff[0]) * DET_W'(adj2_ff[0]);
         t_ff[1] <= DET_W'(top2_ff[1]) * DET_W'(adj2_ff[3]);
         t_ff[2] <= DET_W'(top2_ff[2]) * DET_W'(adj2_ff[6]);
         item4_ff.det      <= det_sum;
         item4_ff.singular <= (det_sum == '0);
      end
   end

   assign out_valid = v4_ff;
   assign out_item  = item4_ff;

endmodule

// ===== rtl/mi3_queue.sv =====
module mi3_queue
   import mi3_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  front_item_type push_item,
   output logic           pop_valid,
   input  logic           pop_ready,
   output front_item_type pop_item
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   front_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != (PTR_W+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop  ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(DEPTH)) else $error("queue count over depth");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      wr_ff - rd_ff == count_ff[PTR_W-1:0]) else $error("queue pointers disagree");

endmodule

// ===== rtl/mi3_back.sv =====
module mi3_back
   import mi3_pkg::*;
#(
   parameter int IN_FRAC_BITS  = 12,
   parameter int OUT_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  front_item_type             in_item,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [N_ENTRY*OUT_W-1:0]   out_data,
   output logic [1:0]                 out_flags
);

   localparam int STEPS = CM_W + IN_FRAC_BITS + OUT_FRAC_BITS;

   logic en;
   logic              vld_ff  [STEPS+1];
   logic              sing_ff [STEPS+1];
   logic [DM_W-1:0]   dm_ff   [STEPS+1];
   logic [CM_W-1:0]   cm_ff   [STEPS+1][N_ENTRY];
   logic [DM_W-1:0]   r_ff    [STEPS+1][N_ENTRY];
   logic [Q_W-1:0]    q_ff    [STEPS+1][N_ENTRY];
   logic              big_ff  [STEPS+1][N_ENTRY];
   logic              neg_ff  [STEPS+1][N_ENTRY];

   logic                     ovalid_ff;
   logic [N_ENTRY*OUT_W-1:0] odata_ff, odata_in;
   logic [1:0]               oflags_ff, oflags_in;

   assign en       = !ovalid_ff || out_ready;
   assign in_ready = en;

   // entry stage: magnitudes and signs
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      logic [DET_W-1:0] dabs;
      logic [ADJ_W-1:0] cabs;
      if (en) begin
         dabs = in_item.det[DET_W-1] ? -in_item.det : in_item.det;
         dm_ff[0]   <= dabs[DM_W-1:0];
         sing_ff[0] <= in_item.singular;
         for (int i = 0; i < N_ENTRY; i++) begin
            cabs = in_item.adj[i][ADJ_W-1] ? -in_item.adj[i] : in_item.adj[i];
            cm_ff[0][i]  <= cabs[CM_W-1:0];
            r_ff[0][i]   <= '0;
            q_ff[0][i]   <= '0;
            big_ff[0][i] <= 1'b0;
            neg_ff[0][i] <= in_item.adj[i][ADJ_W-1] ^ in_item.det[DET_W-1];
         end
      end
   end

   // one restoring division step per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      for (genvar i = 0; i < N_ENTRY; i++) begin : g_lane
         logic [DM_W:0] rs, rd;
         logic          ge;

         always_comb begin
            rs = {r_ff[k][i], cm_ff[k][i][CM_W-1]};
            ge = (rs >= {1'b0, dm_ff[k]});
            rd = rs - {1'b0, dm_ff[k]};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               cm_ff[k+1][i]  <= {cm_ff[k][i][CM_W-2:0], 1'b0};
               r_ff[k+1][i]   <= ge ? rd[DM_W-1:0] : rs[DM_W-1:0];
               q_ff[k+1][i]   <= {q_ff[k][i][Q_W-2:0], ge};
               // quotient past the top bit can only saturate
               big_ff[k+1][i] <= big_ff[k][i] | q_ff[k][i][Q_W-1];
               neg_ff[k+1][i] <= neg_ff[k][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dm_ff[k+1]   <= dm_ff[k];
            sing_ff[k+1] <= sing_ff[k];
         end
      end
   end

   // round half away from zero, saturate; a singular item gives zero and no saturation
   always_comb begin
      logic [Q_W:0]   qr;
      logic [Q_W:0]   lim;
      logic           half, sat_l, any_sat;
      logic [OUT_W-1:0] val;
      any_sat  = 1'b0;
      odata_in = '0;
      for (int i = 0; i < N_ENTRY; i++) begin
         half  = ({r_ff[STEPS][i], 1'b0} >= {1'b0, dm_ff[STEPS]});
         qr    = {1'b0, q_ff[STEPS][i]} + (Q_W+1)'(half);
         lim   = neg_ff[STEPS][i] ? (Q_W+1)'(35'h080000000) : (Q_W+1)'(35'h07FFFFFFF);
         sat_l = big_ff[STEPS][i] || (qr > lim);
         if (sat_l) begin
            val = neg_ff[STEPS][i] ? 32'h80000000 : 32'h7FFFFFFF;
         end else begin
            val = neg_ff[STEPS][i] ? -qr[OUT_W-1:0] : qr[OUT_W-1:0];
         end
         if (sing_ff[STEPS]) begin
            val   = '0;
            sat_l = 1'b0;
         end
         any_sat = any_sat | sat_l;
         odata_in[i*OUT_W +: OUT_W] = val;
      end
      oflags_in = {any_sat, sing_ff[STEPS]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (en) begin
         ovalid_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         odata_ff  <= odata_in;
         oflags_ff <= oflags_in;
      end
   end

   assign out_valid = ovalid_ff;
   assign out_data  = odata_ff;
   assign out_flags = oflags_ff;

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && oflags_ff[0] |-> odata_ff == '0) else $error("singular item not zero");
   a_sing_nosat: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && oflags_ff[0] |-> !oflags_ff[1]) else $error("singular item flagged saturated");
   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !en |=> vld_ff[0]) else $error("entry stage lost an item in a stall");

endmodule

// ===== rtl/matrix_inverse_3x3.sv =====
// path: cofactor and determinant stages, then the queue, then the divider: an entry stage,
// one restoring step per quotient bit and an output register
// throughput: one item per cycle unless rsp_tready stalls; nine dividers run side by side
// reset clears the valid bits, the queue pointers and the queue count; no other state
module matrix_inverse_3x3
   import mi3_pkg::*;
#(
   parameter int IN_FRAC_BITS  = 12,
   parameter int OUT_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // row0_col0, row0_col1, row0_col2, row1_col0 .. row2_col2
   input  logic [N_ENTRY*ENTRY_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0 .. inv_r2c2
   output logic [N_ENTRY*OUT_W-1:0]      rsp_tdata,
   // singular, saturated
   output logic [1:0]                    rsp_tuser
);

   logic           f_valid, f_ready, b_valid, b_ready;
   front_item_type f_item, b_item;

   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   mi3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_item   (b_item)
   );

   mi3_back #(
      .IN_FRAC_BITS  (IN_FRAC_BITS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_item   (b_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_flags (rsp_tuser)
   );

endmodule
